// File: sv/lvf_pkg.sv
// package: shared types and constants of the laplacian variance focus core
`timescale 1ns / 1ps
package lvf_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 12;
  localparam int PIX_W  = 8;
  localparam int VAR_W  = 28;
  localparam int MEAN_W = 19;
  localparam int LAP_W  = 13;
  localparam int SQ_W   = 20;

  localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_AW-1:0] REG_MONO_INPUT   = 2'd2;

  localparam logic [CFG_DW-1:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [CFG_DW-1:0] RST_FRAME_HEIGHT = 12'd480;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3, S_ACC1, S_ACC2, S_ACC3,
    S_MUL1, S_MUL2, S_MUL3, S_DIV1, S_DIV2, S_FIN
  } lvf_state_t;

endpackage

// File: sv/laplacian_variance_focus_core.sv
// top level: laplacian variance focus measure over one frame
//
// channel | dir | handshake          | payload
// in_     | in  | in_tvalid/tready   | tdata: chan_b, chan_g, chan_r
// out_    | out | out_tvalid/tready  | tdata: focus_variance_q8, lap_mean_q8
// cfg_    | in  | cfg_we             | cfg_addr, cfg_wdata
//
// each item passes through the accepting idle state, four line memory read
// states and three laplacian accumulate steps, set by the memory port reads;
// no new item is accepted until they end; the last item of a frame adds a
// shift-add multiply and restoring divide sequence before the result is held
// reset is synchronous, active low; line memories are not cleared
// a held result stalls only the next frame end, not the incoming items
`timescale 1ns / 1ps
module laplacian_variance_focus_core #(
  parameter int MAX_WIDTH  = lvf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lvf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [23:0]                in_tdata,   // chan_b, chan_g, chan_r
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [47:0]                out_tdata,  // focus_variance_q8, lap_mean_q8, pad
  input  logic                       cfg_we,
  input  logic [lvf_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [lvf_pkg::CFG_DW-1:0] cfg_wdata
);
  import lvf_pkg::*;

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int HW   = $clog2(MAX_HEIGHT);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HHW  = $clog2(MAX_HEIGHT + 1);
  localparam int NW   = WW + HHW;
  localparam int S1W  = NW + 11;
  localparam int S2W  = NW + 20;
  localparam int PW   = 2 * NW + 32;
  localparam int MB   = S1W;
  localparam int CW   = $clog2(PW + 2);

  logic [CFG_DW-1:0] cfg_w_r, cfg_h_r;
  logic              mono_r;

  lvf_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic [AW-1:0] col_r;
  logic [HW-1:0] row_r;
  logic          sel_r;
  logic signed [S1W-1:0] lap_sum_r;
  logic [S2W-1:0]        lap_sq_r;
  logic [PIX_W-1:0]      cur_r;

  logic [PIX_W-1:0] bank0 [MAX_WIDTH];
  logic [PIX_W-1:0] bank1 [MAX_WIDTH];
  logic [PIX_W-1:0] q0_r, q1_r;
  logic [PIX_W-1:0] n_c_r, n_l_r, n_r_r, o_c_r, o_m1_r, o_m2_r;

  logic [PW-1:0]  mcand_r, prod_r, p1_r, d_r, num_r, rem_r, dvs_r;
  logic [MB-1:0]  mplier_r;
  logic [VAR_W-1:0] quo_r, var_r;

  logic              out_valid_r;
  logic [VAR_W-1:0]  out_var_r;
  logic [MEAN_W-1:0] out_mean_r;

  // effective frame size
  logic [31:0]    cw32, ch32;
  logic [WW-1:0]  w_eff;
  logic [HHW-1:0] h_eff;
  logic [NW-1:0]  n_val;
  assign cw32  = {20'd0, cfg_w_r};
  assign ch32  = {20'd0, cfg_h_r};
  assign w_eff = (cw32 < 32'd2) ? WW'(2) : (cw32 > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) :
                 cw32[WW-1:0];
  assign h_eff = (ch32 < 32'd2) ? HHW'(2) : (ch32 > 32'(MAX_HEIGHT)) ? HHW'(MAX_HEIGHT) :
                 ch32[HHW-1:0];
  assign n_val = NW'(w_eff) * NW'(h_eff);

  logic col_last, row_last, col_ge1, col_ge2, row_ge1, row_ge2;
  assign col_last = (WW'(col_r) + WW'(1)) >= w_eff;
  assign row_last = (HHW'(row_r) + HHW'(1)) >= h_eff;
  assign col_ge1  = col_r != '0;
  assign col_ge2  = col_r > AW'(1);
  assign row_ge1  = row_r != '0;
  assign row_ge2  = row_r > HW'(1);

  // gray conversion
  logic [21:0] gray_sum;
  logic [PIX_W-1:0] gray;
  assign gray_sum = 22'd1868 * 22'(in_tdata[7:0]) + 22'd9617 * 22'(in_tdata[15:8]) +
                    22'd4899 * 22'(in_tdata[23:16]) + 22'd8192;
  assign gray = mono_r ? in_tdata[7:0] : gray_sum[21:14];

  // memory addressing
  logic [AW-1:0] new_addr, old_addr, a0, a1;
  always_comb begin
    new_addr = col_r;
    old_addr = col_r;
    unique case (state_r)
      S_RD1: begin
        new_addr = col_ge1 ? col_r - AW'(1) : AW'(1);
        old_addr = col_r - AW'(1);
      end
      S_RD2: begin
        new_addr = col_last ? AW'(w_eff - WW'(2)) : col_r + AW'(1);
        old_addr = col_r - AW'(2);
      end
      default: begin
        new_addr = col_r;
        old_addr = col_r;
      end
    endcase
  end
  assign a0 = sel_r ? old_addr : new_addr;
  assign a1 = sel_r ? new_addr : old_addr;

  logic [PIX_W-1:0] newq, oldq;
  assign newq = sel_r ? q1_r : q0_r;
  assign oldq = sel_r ? q0_r : q1_r;

  logic wr_en;
  assign wr_en = state_r == S_ACC3;

  always_ff @(posedge clk) begin
    q0_r <= bank0[a0];
    q1_r <= bank1[a1];
    if (wr_en && sel_r)  bank0[col_r] <= cur_r;
    if (wr_en && !sel_r) bank1[col_r] <= cur_r;
  end

  // laplacian term
  logic signed [LAP_W-1:0] ta, tb, tc, td, te, lap_v;
  logic signed [2*LAP_W-1:0] lap_sq;
  logic acc_en;
  function automatic logic signed [LAP_W-1:0] sx(input logic [PIX_W-1:0] p);
    return signed'(LAP_W'(p));
  endfunction
  always_comb begin
    ta = sx(n_c_r); tb = ta; tc = ta; td = ta; te = ta;
    acc_en = 1'b0;
    unique case (state_r)
      S_ACC1: begin
        ta = row_ge2 ? sx(o_c_r) : sx(cur_r);
        tb = sx(cur_r); tc = sx(n_l_r); td = sx(n_r_r); te = sx(n_c_r);
        acc_en = row_ge1;
      end
      S_ACC2: begin
        ta = sx(n_l_r); tb = sx(n_l_r);
        tc = col_ge2 ? sx(o_m2_r) : sx(cur_r);
        td = sx(cur_r); te = sx(o_m1_r);
        acc_en = row_last && col_ge1;
      end
      S_ACC3: begin
        ta = sx(n_c_r); tb = sx(n_c_r); tc = sx(o_m1_r); td = sx(o_m1_r); te = sx(cur_r);
        acc_en = row_last && col_ge1 && col_last;
      end
      default: acc_en = 1'b0;
    endcase
  end
  assign lap_v  = ta + tb + tc + td - (te <<< 2);
  assign lap_sq = lap_v * lap_v;

  logic [S1W-1:0] mag;
  assign mag = lap_sum_r[S1W-1] ? S1W'(-lap_sum_r) : S1W'(lap_sum_r);

  // divider step
  logic [PW-1:0] rem_sh;
  logic          q_bit;
  assign rem_sh = {rem_r[PW-2:0], num_r[PW-1]};
  assign q_bit  = rem_sh >= dvs_r;

  logic mul_step, div_step, op_load, mul_done, div_done;
  assign op_load  = cnt_r == '0;
  assign mul_step = !op_load && cnt_r <= CW'(MB);
  assign div_step = !op_load && cnt_r <= CW'(PW);
  assign mul_done = cnt_r == CW'(MB + 1);
  assign div_done = cnt_r == CW'(PW + 1);

  // control
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = S_RD0;
      end
      S_RD0:  state_nxt = S_RD1;
      S_RD1:  state_nxt = S_RD2;
      S_RD2:  state_nxt = S_RD3;
      S_RD3:  state_nxt = S_ACC1;
      S_ACC1: state_nxt = S_ACC2;
      S_ACC2: state_nxt = S_ACC3;
      S_ACC3: state_nxt = (col_last && row_last) ? S_MUL1 : S_IDLE;
      S_MUL1: begin
        cnt_nxt = cnt_r + CW'(1);
        if (mul_done) begin state_nxt = S_MUL2; cnt_nxt = '0; end
      end
      S_MUL2: begin
        cnt_nxt = cnt_r + CW'(1);
        if (mul_done) begin state_nxt = S_MUL3; cnt_nxt = '0; end
      end
      S_MUL3: begin
        cnt_nxt = cnt_r + CW'(1);
        if (mul_done) begin state_nxt = S_DIV1; cnt_nxt = '0; end
      end
      S_DIV1: begin
        cnt_nxt = cnt_r + CW'(1);
        if (div_done) begin state_nxt = S_DIV2; cnt_nxt = '0; end
      end
      S_DIV2: begin
        cnt_nxt = cnt_r + CW'(1);
        if (div_done) begin state_nxt = S_FIN; cnt_nxt = '0; end
      end
      S_FIN: if (!out_valid_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // position, accumulators, configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r   <= RST_FRAME_WIDTH;
      cfg_h_r   <= RST_FRAME_HEIGHT;
      mono_r    <= 1'b0;
      col_r     <= '0;
      row_r     <= '0;
      sel_r     <= 1'b0;
      lap_sum_r <= '0;
      lap_sq_r  <= '0;
    end else if (cfg_we && (cfg_addr == REG_FRAME_WIDTH || cfg_addr == REG_FRAME_HEIGHT ||
                            cfg_addr == REG_MONO_INPUT)) begin
      if (cfg_addr == REG_FRAME_WIDTH)  cfg_w_r <= cfg_wdata;
      if (cfg_addr == REG_FRAME_HEIGHT) cfg_h_r <= cfg_wdata;
      if (cfg_addr == REG_MONO_INPUT)   mono_r  <= cfg_wdata[0];
      col_r     <= '0;
      row_r     <= '0;
      lap_sum_r <= '0;
      lap_sq_r  <= '0;
    end else begin
      if (acc_en) begin
        lap_sum_r <= lap_sum_r + S1W'(lap_v);
        lap_sq_r  <= lap_sq_r + S2W'(lap_sq[SQ_W-1:0]);
      end
      if (state_r == S_ACC3) begin
        if (!col_last) begin
          col_r <= col_r + AW'(1);
        end else begin
          col_r <= '0;
          sel_r <= ~sel_r;
          if (!row_last) row_r <= row_r + HW'(1);
        end
      end
      if (state_r == S_FIN && !out_valid_r) begin
        row_r     <= '0;
        lap_sum_r <= '0;
        lap_sq_r  <= '0;
      end
    end
  end

  // pixel capture and frame end arithmetic
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: cur_r <= gray;
      S_RD1: begin n_c_r <= newq; o_c_r <= oldq; end
      S_RD2: begin n_l_r <= newq; o_m1_r <= oldq; end
      S_RD3: begin n_r_r <= newq; o_m2_r <= oldq; end
      S_MUL1, S_MUL2, S_MUL3: begin
        if (op_load) begin
          prod_r <= '0;
          if (state_r == S_MUL1) begin
            mcand_r  <= PW'(lap_sq_r);
            mplier_r <= MB'(n_val);
          end else if (state_r == S_MUL2) begin
            p1_r     <= prod_r;
            mcand_r  <= PW'(mag);
            mplier_r <= MB'(mag);
          end else begin
            d_r      <= (p1_r - prod_r) << 8;
            mcand_r  <= PW'(n_val);
            mplier_r <= MB'(n_val);
          end
        end else if (mul_step) begin
          if (mplier_r[0]) prod_r <= prod_r + mcand_r;
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
        end
      end
      S_DIV1, S_DIV2: begin
        if (op_load) begin
          rem_r <= '0;
          quo_r <= '0;
          if (state_r == S_DIV1) begin
            num_r <= d_r;
            dvs_r <= prod_r;
          end else begin
            var_r <= quo_r;
            num_r <= PW'(mag) << 8;
            dvs_r <= PW'(n_val);
          end
        end else if (div_step) begin
          rem_r <= q_bit ? rem_sh - dvs_r : rem_sh;
          quo_r <= {quo_r[VAR_W-2:0], q_bit};
          num_r <= num_r << 1;
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && !out_valid_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && !out_valid_r) begin
      out_var_r  <= var_r;
      out_mean_r <= lap_sum_r[S1W-1] ? MEAN_W'(-quo_r) : quo_r[MEAN_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_mean_r, out_var_r};

`ifndef SYNTHESIS
  a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_RD0)
    else $error("accepted item did not start memory reads");
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result raised outside frame end");
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV1 || state_r == S_DIV2) && cnt_r != '0 |-> rem_r < dvs_r)
    else $error("divider remainder not below divisor");
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ACC3 |=> !in_tready || !(col_last && row_last) || state_r == S_IDLE)
    else $error("ready during frame end arithmetic");
`endif

endmodule
